// File: design/assert_macros.svh
// Assertion macros used by the checker file of this block.
// Self-contained; no other file is needed.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the reset input is high.
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked while the reset input is high.
`define ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/yuv2rgb_pkg.sv
// Types, constants and arithmetic helpers for the YUYV to RGB converter.
// No dependencies; every other design file except assert_macros.svh imports this package.
package yuv2rgb_pkg;

   // Conversion coefficients, unsigned with 16 fraction bits.
   localparam logic [16:0] CoefRedV   = 17'd89831;
   localparam logic [16:0] CoefGreenV = 17'd45744;
   localparam logic [16:0] CoefGreenU = 17'd22127;
   localparam logic [16:0] CoefBlueU  = 17'd113538;

   localparam logic [8:0] ChromaOffset = 9'd128;
   localparam logic [8:0] GainReset    = 9'd220;

   // Widths of a chroma product and of a channel sum, both signed.
   localparam int ProdWidth = 27;
   localparam int SumWidth  = 28;

   typedef struct packed {
      logic [7:0] luma_first;
      logic [7:0] chroma_blue;
      logic [7:0] luma_second;
      logic [7:0] chroma_red;
      logic       end_of_frame;
   } req_data_type;

   typedef struct packed {
      logic [7:0] red_first;
      logic [7:0] green_first;
      logic [7:0] blue_first;
      logic [7:0] red_second;
      logic [7:0] green_second;
      logic [7:0] blue_second;
      logic       end_of_frame_out;
   } rsp_data_type;

   typedef struct packed {
      logic signed [ProdWidth-1:0] red_v;
      logic signed [ProdWidth-1:0] green_v;
      logic signed [ProdWidth-1:0] green_u;
      logic signed [ProdWidth-1:0] blue_u;
   } products_type;

   typedef struct packed {
      logic [7:0]   luma_first;
      logic [7:0]   luma_second;
      logic         end_of_frame;
      products_type products;
   } chroma_stage_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   typedef struct packed {
      logic sum_load;
      logic gain_load;
   } lane_ctrl_type;

   // Truncate a 16-fraction-bit sum to its integer part and clamp to 0..255.
   function automatic logic [7:0] clamp_channel(input logic signed [SumWidth-1:0] sum);
      logic [7:0] result;
      if (sum[SumWidth-1]) begin
         result = 8'd0;
      end else if (|sum[SumWidth-2:24]) begin
         result = 8'hFF;
      end else begin
         result = sum[23:16];
      end
      return result;
   endfunction

   // Channel times gain over 256, floored, saturated at 255.
   function automatic logic [7:0] apply_gain(input logic [7:0] channel,
                                             input logic [8:0] gain);
      logic [16:0] product;
      logic [8:0]  scaled;
      logic [7:0]  result;
      product = {9'd0, channel} * {8'd0, gain};
      scaled  = product[16:8];
      result  = scaled[8] ? 8'hFF : scaled[7:0];
      return result;
   endfunction

endpackage

// File: design/yuv2rgb_chroma.sv
// Shared chroma stage: the four coefficient products, registered with the lumas.
// Depends on yuv2rgb_pkg.
module yuv2rgb_chroma
   import yuv2rgb_pkg::*;
(
   input  logic             clock,
   input  logic             load,
   input  req_data_type     req_data,
   output chroma_stage_type stage_ff
);

   logic signed [8:0] delta_u;
   logic signed [8:0] delta_v;
   chroma_stage_type  stage_in;

   always_comb begin
      delta_u = $signed({1'b0, req_data.chroma_blue}) - $signed(ChromaOffset);
      delta_v = $signed({1'b0, req_data.chroma_red}) - $signed(ChromaOffset);

      stage_in.luma_first       = req_data.luma_first;
      stage_in.luma_second      = req_data.luma_second;
      stage_in.end_of_frame     = req_data.end_of_frame;
      stage_in.products.red_v   = ProdWidth'($signed({1'b0, CoefRedV}) * delta_v);
      stage_in.products.green_v = ProdWidth'($signed({1'b0, CoefGreenV}) * delta_v);
      stage_in.products.green_u = ProdWidth'($signed({1'b0, CoefGreenU}) * delta_u);
      stage_in.products.blue_u  = ProdWidth'($signed({1'b0, CoefBlueU}) * delta_u);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         stage_ff <= stage_in;
      end
   end

endmodule

// File: design/yuv2rgb_lane.sv
// One pixel lane: channel sums with clamp, then the gain multiply.
// Depends on yuv2rgb_pkg.
module yuv2rgb_lane
   import yuv2rgb_pkg::*;
(
   input  logic          clock,
   input  lane_ctrl_type ctrl,
   input  logic [7:0]    luma,
   input  products_type  products,
   input  logic [8:0]    gain,
   output pixel_type     pixel_ff
);

   logic signed [SumWidth-1:0] base;
   logic signed [SumWidth-1:0] sum_red;
   logic signed [SumWidth-1:0] sum_green;
   logic signed [SumWidth-1:0] sum_blue;
   pixel_type                  clamp_in;
   pixel_type                  clamp_ff;
   pixel_type                  pixel_in;

   always_comb begin
      base      = SumWidth'($signed({1'b0, luma, 16'd0}));
      sum_red   = base + SumWidth'(products.red_v);
      sum_green = base - SumWidth'(products.green_v) - SumWidth'(products.green_u);
      sum_blue  = base + SumWidth'(products.blue_u);

      clamp_in.red   = clamp_channel(sum_red);
      clamp_in.green = clamp_channel(sum_green);
      clamp_in.blue  = clamp_channel(sum_blue);

      pixel_in.red   = apply_gain(clamp_ff.red, gain);
      pixel_in.green = apply_gain(clamp_ff.green, gain);
      pixel_in.blue  = apply_gain(clamp_ff.blue, gain);
   end

   always_ff @(posedge clock) begin
      if (ctrl.sum_load) begin
         clamp_ff <= clamp_in;
      end
      if (ctrl.gain_load) begin
         pixel_ff <= pixel_in;
      end
   end

endmodule

// File: design/yuv2rgb_merge.sv
// Output register: joins both lanes and the frame-end flag into one response.
// Depends on yuv2rgb_pkg.
module yuv2rgb_merge
   import yuv2rgb_pkg::*;
(
   input  logic         clock,
   input  logic         load,
   input  pixel_type    pixel_first,
   input  pixel_type    pixel_second,
   input  logic         end_of_frame,
   output rsp_data_type rsp_data_ff
);

   rsp_data_type rsp_data_in;

   always_comb begin
      rsp_data_in.red_first        = pixel_first.red;
      rsp_data_in.green_first      = pixel_first.green;
      rsp_data_in.blue_first       = pixel_first.blue;
      rsp_data_in.red_second       = pixel_second.red;
      rsp_data_in.green_second     = pixel_second.green;
      rsp_data_in.blue_second      = pixel_second.blue;
      rsp_data_in.end_of_frame_out = end_of_frame;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// File: design/yuyv_to_rgb_converter.sv
// Top level of the YUYV 4:2:2 to RGB888 converter.
// Depends on yuv2rgb_pkg, yuv2rgb_chroma, yuv2rgb_lane and yuv2rgb_merge.
//
//   Channel  Ports                             Moves
//   req      req_valid, req_stall, req_data    one YUYV word and frame-end flag
//   rsp      rsp_valid, rsp_stall, rsp_data    two RGB pixels and frame-end flag
//   csr      csr_write_enable, csr_write_data  output gain, 9 bits
//
// A transaction accepted at one edge moves through the chroma products, the per-lane sum
// and clamp and the gain multiply into the output register, which holds its response until
// the receiver takes it. One transaction is accepted per cycle unless a stalled response
// backs up the pipeline; the split of the arithmetic sets the depth.
// Reset is synchronous; it empties the pipeline and loads the gain with 220.
// Stalls ripple back only through full stages, so input keeps flowing into
// empty stages while a finished response waits on rsp_stall.
module yuyv_to_rgb_converter
   import yuv2rgb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_data_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_data_type rsp_data,
   input  logic         csr_write_enable,
   input  logic [8:0]   csr_write_data
);

   // Gain register; the user must write it only while the block is idle, which the block does not enforce.
   logic [8:0] gain_ff;
   logic [8:0] gain_in;

   // Occupancy of the chroma, sum, gain and output stages.
   logic chroma_valid_ff;
   logic chroma_valid_in;
   logic sum_valid_ff;
   logic sum_valid_in;
   logic gain_valid_ff;
   logic gain_valid_in;
   logic out_valid_ff;
   logic out_valid_in;

   // A stage may load when it is empty or when the stage after it moves on.
   logic out_ready;
   logic gain_ready;
   logic sum_ready;
   logic chroma_ready;

   // The frame-end flag rides alongside the lane stages.
   logic sum_eof_ff;
   logic gain_eof_ff;

   chroma_stage_type chroma_stage;
   lane_ctrl_type    lane_ctrl;
   pixel_type        pixel_first;
   pixel_type        pixel_second;

   always_comb begin
      out_ready    = !out_valid_ff || !rsp_stall;
      gain_ready   = !gain_valid_ff || out_ready;
      sum_ready    = !sum_valid_ff || gain_ready;
      chroma_ready = !chroma_valid_ff || sum_ready;

      chroma_valid_in = chroma_ready ? req_valid : chroma_valid_ff;
      sum_valid_in    = sum_ready ? chroma_valid_ff : sum_valid_ff;
      gain_valid_in   = gain_ready ? sum_valid_ff : gain_valid_ff;
      out_valid_in    = out_ready ? gain_valid_ff : out_valid_ff;

      gain_in = csr_write_enable ? csr_write_data : gain_ff;

      // Payload registers only load when real data moves into them.
      lane_ctrl.sum_load  = sum_ready && chroma_valid_ff;
      lane_ctrl.gain_load = gain_ready && sum_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff         <= GainReset;
         chroma_valid_ff <= 1'b0;
         sum_valid_ff    <= 1'b0;
         gain_valid_ff   <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         gain_ff         <= gain_in;
         chroma_valid_ff <= chroma_valid_in;
         sum_valid_ff    <= sum_valid_in;
         gain_valid_ff   <= gain_valid_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (lane_ctrl.sum_load) begin
         sum_eof_ff <= chroma_stage.end_of_frame;
      end
      if (lane_ctrl.gain_load) begin
         gain_eof_ff <= sum_eof_ff;
      end
   end

   // The chroma differences and their products are shared by both pixels.
   yuv2rgb_chroma u_chroma (
      .clock    (clock),
      .load     (chroma_ready && req_valid),
      .req_data (req_data),
      .stage_ff (chroma_stage)
   );

   // One lane per pixel of the transaction.
   yuv2rgb_lane u_lane_first (
      .clock    (clock),
      .ctrl     (lane_ctrl),
      .luma     (chroma_stage.luma_first),
      .products (chroma_stage.products),
      .gain     (gain_ff),
      .pixel_ff (pixel_first)
   );

   yuv2rgb_lane u_lane_second (
      .clock    (clock),
      .ctrl     (lane_ctrl),
      .luma     (chroma_stage.luma_second),
      .products (chroma_stage.products),
      .gain     (gain_ff),
      .pixel_ff (pixel_second)
   );

   yuv2rgb_merge u_merge (
      .clock        (clock),
      .load         (out_ready && gain_valid_ff),
      .pixel_first  (pixel_first),
      .pixel_second (pixel_second),
      .end_of_frame (gain_eof_ff),
      .rsp_data_ff  (rsp_data)
   );

   assign req_stall = !chroma_ready;
   assign rsp_valid = out_valid_ff;

endmodule

// File: design/yuv2rgb_checker.sv
// Port-level checks for the YUYV to RGB converter, bound to the top level.
// Depends on yuv2rgb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module yuv2rgb_checker
   import yuv2rgb_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_data_type rsp_data
);

   // A stalled response keeps its valid and its payload.
   `ASSERT_CLK_RST(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "response changed while stalled")

   // Reset empties the pipeline.
   `ASSERT_CLK(a_reset_empty, clock, reset |=> !rsp_valid, "response valid right after reset")

   // Input is only held off when a finished response is waiting.
   `ASSERT_CLK_RST(a_no_false_stall, clock, reset, !(rsp_valid && rsp_stall) |-> !req_stall, "input stalled with free output")

   // With the output flowing, an accepted transaction reaches the output.
   `ASSERT_CLK_RST(a_latency, clock, reset, req_valid && !req_stall ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall |=> rsp_valid, "response missing after four cycles")

endmodule

bind yuyv_to_rgb_converter yuv2rgb_checker u_checker (.*);

// File: test/yuv2rgb_checker.sv
// Scoreboard for the YUYV to RGB converter: predicts every response and compares it.
// Depends on yuv2rgb_pkg for the transaction and pixel types.
module yuv2rgb_scoreboard
   import yuv2rgb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_stall,
   input  req_data_type req_data,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  rsp_data_type rsp_data,
   input  logic         csr_write_enable,
   input  logic [8:0]   csr_write_data,
   output int           error_count,
   output int           pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // Color matrix weights with 16 fraction bits.
   localparam longint RedFromV   = 89831;
   localparam longint GreenFromV = 45744;
   localparam longint GreenFromU = 22127;
   localparam longint BlueFromU  = 113538;
   localparam longint LumaScale  = 65536;
   localparam longint ChromaBias = 128;
   localparam logic [8:0] GainAfterReset = 9'd220;

   logic [8:0]   brightness_gain = GainAfterReset;
   rsp_data_type expected_pixels [$];
   rsp_data_type oldest_pixels;

   initial error_count = 0;
   initial pending_count = 0;

   // Negative sums give zero; others keep their integer part, capped at 255.
   function automatic logic [7:0] clamp_to_byte(input longint fixed_sum);
      longint whole;
      whole = fixed_sum >>> 16;
      if (fixed_sum < 0) begin
         return 8'd0;
      end
      return (whole > 255) ? 8'd255 : whole[7:0];
   endfunction

   function automatic logic [7:0] scale_by_gain(input logic [7:0] level,
                                                input logic [8:0] gain);
      int scaled;
      scaled = (int'(level) * int'(gain)) >>> 8;
      return (scaled > 255) ? 8'd255 : scaled[7:0];
   endfunction

   function automatic pixel_type convert_pixel(input logic [7:0] luma, input longint du,
                                               input longint dv, input logic [8:0] gain);
      longint    base;
      pixel_type pixel;
      base = longint'(luma) * LumaScale;
      pixel.red   = scale_by_gain(clamp_to_byte(base + RedFromV * dv), gain);
      pixel.green = scale_by_gain(clamp_to_byte(base - GreenFromV * dv - GreenFromU * du),
                                  gain);
      pixel.blue  = scale_by_gain(clamp_to_byte(base + BlueFromU * du), gain);
      return pixel;
   endfunction

   function automatic rsp_data_type convert_word(input req_data_type word,
                                                 input logic [8:0] gain);
      longint       du;
      longint       dv;
      pixel_type    first;
      pixel_type    second;
      rsp_data_type pixels;
      du     = longint'(word.chroma_blue) - ChromaBias;
      dv     = longint'(word.chroma_red) - ChromaBias;
      first  = convert_pixel(word.luma_first, du, dv, gain);
      second = convert_pixel(word.luma_second, du, dv, gain);
      pixels.red_first        = first.red;
      pixels.green_first      = first.green;
      pixels.blue_first       = first.blue;
      pixels.red_second       = second.red;
      pixels.green_second     = second.green;
      pixels.blue_second      = second.blue;
      pixels.end_of_frame_out = word.end_of_frame;
      return pixels;
   endfunction

   task automatic compare_channel(input string label, input logic [7:0] want,
                                  input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_pixels.delete();
         brightness_gain = GainAfterReset;
      end else begin
         if (csr_write_enable) begin
            brightness_gain = csr_write_data;
         end
         if (req_valid && !req_stall) begin
            expected_pixels.insert(expected_pixels.size(),
                                   convert_word(req_data, brightness_gain));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               $display("%0t: response with nothing expected, actual %h", $time, rsp_data);
               error_count++;
            end else begin
               oldest_pixels = expected_pixels.pop_front();
               compare_channel("red_first", oldest_pixels.red_first, rsp_data.red_first);
               compare_channel("green_first", oldest_pixels.green_first,
                               rsp_data.green_first);
               compare_channel("blue_first", oldest_pixels.blue_first, rsp_data.blue_first);
               compare_channel("red_second", oldest_pixels.red_second, rsp_data.red_second);
               compare_channel("green_second", oldest_pixels.green_second,
                               rsp_data.green_second);
               compare_channel("blue_second", oldest_pixels.blue_second,
                               rsp_data.blue_second);
               compare_channel("end_of_frame_out", {7'd0, oldest_pixels.end_of_frame_out},
                               {7'd0, rsp_data.end_of_frame_out});
            end
         end
      end
      pending_count = expected_pixels.size();
   end

endmodule

// File: test/tb_yuyv_to_rgb_converter.sv
// Top of the YUYV to RGB converter testbench: clock, reset, stimulus and verdict.
// Depends on yuv2rgb_pkg, the yuyv_to_rgb_converter design and yuv2rgb_scoreboard.
module tb_yuyv_to_rgb_converter;
   timeunit 1ns;
   timeprecision 1ps;
   import yuv2rgb_pkg::*;

   // This limit leaves a wide margin over the length of the run.
   localparam int CycleLimit     = 200000;
   localparam int WordsPerPhase  = 210;
   localparam int GainPhases     = 8;
   localparam int DrainCycles    = 8;
   // Receiver behavior; the response thresholds are counted in accepted response transactions.
   localparam int SteadyRspFrom  = 400;
   localparam int SteadyRspTo    = 650;
   localparam int HoldAfterRsp   = 900;
   localparam int HoldCycles     = 300;
   localparam int IdlePercent    = 16;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_data_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_data_type rsp_data;
   logic         csr_write_enable = 1'b0;
   logic [8:0]   csr_write_data = '0;

   int error_count;
   int pending_count;
   int cycle_count = 0;
   int responses_taken = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   bit steady_sender = 1'b0;

   logic [8:0]   phase_gain [GainPhases];
   logic [7:0]   corner_samples [7] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd129, 8'd254, 8'd255};
   req_data_type corner_words [18] = '{
      {8'd0,   8'd0,   8'd0,   8'd0,   1'b0},
      {8'd255, 8'd255, 8'd255, 8'd255, 1'b1},
      {8'd0,   8'd128, 8'd255, 8'd128, 1'b0},
      {8'd0,   8'd0,   8'd0,   8'd0,   1'b1},
      {8'd255, 8'd0,   8'd0,   8'd255, 1'b0},
      {8'd0,   8'd255, 8'd255, 8'd0,   1'b0},
      {8'd128, 8'd128, 8'd129, 8'd129, 1'b1},
      {8'd1,   8'd129, 8'd254, 8'd127, 1'b0},
      {8'd128, 8'd0,   8'd128, 8'd255, 1'b0},
      {8'd128, 8'd255, 8'd128, 8'd0,   1'b1},
      {8'd16,  8'd128, 8'd235, 8'd128, 1'b0},
      {8'd100, 8'd127, 8'd100, 8'd129, 1'b0},
      {8'd0,   8'd129, 8'd0,   8'd129, 1'b1},
      {8'd255, 8'd127, 8'd255, 8'd127, 1'b0},
      {8'd170, 8'd85,  8'd85,  8'd170, 1'b1},
      {8'd85,  8'd170, 8'd170, 8'd85,  1'b0},
      {8'd254, 8'd1,   8'd1,   8'd254, 1'b1},
      {8'd240, 8'd16,  8'd16,  8'd240, 1'b0}
   };

   yuyv_to_rgb_converter dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // The checker watches both channels and the gain writes on its own.
   yuv2rgb_scoreboard scoreboard (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .error_count      (error_count),
      .pending_count    (pending_count)
   );

   always #5 clock = ~clock;

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Response side. It stalls at random, except for one steady stretch, and once
   // holds off for a long time so that the pipeline fills and the block has to
   // stall the request channel.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            responses_taken++;
         end
         if (responses_taken >= HoldAfterRsp && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HoldCycles;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (responses_taken >= SteadyRspFrom && responses_taken < SteadyRspTo) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < IdlePercent);
         end
      end
   end

   // Samples lean toward the corners of the range, where the clamps act, but
   // most are spread over the whole byte so that every bit toggles.
   function automatic logic [7:0] random_sample();
      if ($urandom_range(3) == 0) begin
         return corner_samples[$urandom_range(6)];
      end
      return 8'($urandom_range(255));
   endfunction

   function automatic req_data_type random_word();
      req_data_type word;
      word.luma_first   = random_sample();
      word.chroma_blue  = random_sample();
      word.luma_second  = random_sample();
      word.chroma_red   = random_sample();
      word.end_of_frame = ($urandom_range(7) == 0);
      return word;
   endfunction

   // Offers one transaction and returns at the edge that accepts it. Random idle
   // cycles come first unless the sender is in its steady stretch. Valid gets a
   // single assignment per edge, so back-to-back transactions keep it high.
   task automatic send_word(input req_data_type word);
      while (!steady_sender && ($urandom_range(99) < IdlePercent)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= word;
      do begin
         @(posedge clock);
      end while (req_stall);
   endtask

   // Lets every outstanding response come back and the pipeline settle before anything else.
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      do begin
         @(negedge clock);
      end while (pending_count != 0);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // Gain writes are only issued while the block is empty.
   task automatic write_gain(input logic [8:0] gain);
      csr_write_enable <= 1'b1;
      csr_write_data   <= gain;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      // Phase zero runs on the gain that reset loads. The others cover the full
      // nine-bit range: unity, zero, the largest value, gains above unity where
      // the output saturates, and random settings.
      phase_gain[1] = 9'd256;
      phase_gain[2] = 9'd0;
      phase_gain[3] = 9'd511;
      phase_gain[4] = 9'd255;
      phase_gain[5] = 9'($urandom_range(511));
      phase_gain[6] = 9'd1;
      phase_gain[7] = 9'($urandom_range(511, 257));

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed transactions: extreme samples, neutral chroma, chroma at both
      // ends, sums just past zero and just past 255, and both frame-end values.
      foreach (corner_words[k]) begin
         send_word(corner_words[k]);
      end

      for (int phase = 0; phase < GainPhases; phase++) begin
         if (phase > 0) begin
            wait_until_drained();
            write_gain(phase_gain[phase]);
         end
         // The zero-gain phase is offered with no gaps on the request side.
         steady_sender = (phase == 2);
         for (int n = 0; n < WordsPerPhase; n++) begin
            send_word(random_word());
         end
      end
      steady_sender = 1'b0;

      wait_until_drained();
      if (error_count == 0 && pending_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+design
design/yuv2rgb_pkg.sv
design/yuv2rgb_chroma.sv
design/yuv2rgb_lane.sv
design/yuv2rgb_merge.sv
design/yuyv_to_rgb_converter.sv
design/yuv2rgb_checker.sv
test/yuv2rgb_checker.sv
test/tb_yuyv_to_rgb_converter.sv
